// ----- rtl/core/tea_block_decrypt_core_macros.svh -----
// Assertion macros shared by the TEA decrypt core RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TEA_BLOCK_DECRYPT_CORE_MACROS_SVH
`define TEA_BLOCK_DECRYPT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tbd_pkg.sv -----
// Types, constants and helper functions of the TEA decrypt core.
// No dependencies; compiled before every other RTL file.
package tbd_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned KEY_IDX_W  = 2;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // Configuration register indexes.
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_A = 2'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_B = 2'd1;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_C = 2'd2;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_D = 2'd3;

    // Key register reset values.
    localparam logic [WORD_W-1:0] KEY_A_RESET = 32'd128;
    localparam logic [WORD_W-1:0] KEY_B_RESET = 32'd129;
    localparam logic [WORD_W-1:0] KEY_C_RESET = 32'd130;
    localparam logic [WORD_W-1:0] KEY_D_RESET = 32'd131;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_key;

    typedef struct packed {
        t_word left;
        t_word right;
    } t_block;

    // Running sum of a round, n rounds from the end: n * delta modulo 2^32.
    // Only evaluated at elaboration.
    function automatic t_word round_sum(input int unsigned n);
        logic [2*WORD_W-1:0] product;
        product = (2*WORD_W)'(n) * (2*WORD_W)'(TEA_DELTA);
        return product[WORD_W-1:0];
    endfunction

endpackage

// ----- rtl/core/tbd_channels_if.sv -----
// Valid/ready channel interfaces for ciphertext and plaintext words.
// Depends on nothing; compiled after tbd_pkg.
interface tbd_cipher_if;
    logic        valid;
    logic        ready;
    logic [31:0] cipher_left;
    logic [31:0] cipher_right;

    modport source (output valid, output cipher_left, output cipher_right, input ready);
    modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

interface tbd_plain_if;
    logic        valid;
    logic        ready;
    logic [31:0] plain_left;
    logic [31:0] plain_right;

    modport source (output valid, output plain_left, output plain_right, input ready);
    modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

// ----- rtl/core/tbd_key_bank.sv -----
// Key register bank of the TEA decrypt core, written through the config port.
// Depends on tbd_pkg and the assertion macro header.
`include "tea_block_decrypt_core_macros.svh"

module tbd_key_bank (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbd_pkg::KEY_IDX_W-1:0]  i_cfg_index,
    input  logic [tbd_pkg::WORD_W-1:0]     i_cfg_data,
    output tbd_pkg::t_key                  o_key
);
    import tbd_pkg::*;

    t_key r_key;
    t_key n_key;

    always_comb begin
        n_key = r_key;
        if (i_cfg_we) begin
            case (i_cfg_index)
                KEY_IDX_A: n_key.a = i_cfg_data;
                KEY_IDX_B: n_key.b = i_cfg_data;
                KEY_IDX_C: n_key.c = i_cfg_data;
                KEY_IDX_D: n_key.d = i_cfg_data;
                default:   n_key   = r_key;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.a <= KEY_A_RESET;
            r_key.b <= KEY_B_RESET;
            r_key.c <= KEY_C_RESET;
            r_key.d <= KEY_D_RESET;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;

    `TBD_ASSERT_NEXT(a_key_a_write, i_clk, i_rst_n, i_cfg_we && (i_cfg_index == KEY_IDX_A), r_key.a == $past(i_cfg_data), "key word a not written")
    `TBD_ASSERT_NEXT(a_key_hold, i_clk, i_rst_n, !i_cfg_we, r_key == $past(r_key), "key changed without a write")
    `TBD_ASSERT_NEXT(a_key_d_write, i_clk, i_rst_n, i_cfg_we && (i_cfg_index == KEY_IDX_D), r_key.d == $past(i_cfg_data), "key word d not written")

endmodule

// ----- rtl/core/tbd_half_cell.sv -----
// One half-round cell of the TEA decryption chain: updates one word of the block.
// Depends on tbd_pkg and the assertion macro header.
`include "tea_block_decrypt_core_macros.svh"

module tbd_half_cell #(
    parameter bit          UPDATE_RIGHT = 1'b1,
    parameter logic [31:0] ROUND_SUM    = 32'h0000_0000
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tbd_pkg::t_block i_block,
    input  tbd_pkg::t_key   i_key,
    output logic            o_valid,
    input  logic            i_next_ready,
    output tbd_pkg::t_block o_block
);
    import tbd_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_block r_block;
    t_block n_block;
    t_word  src;
    t_word  key_lo;
    t_word  key_hi;
    t_word  mix;
    logic   load;

    // The right-word half mixes the left word with keys c and d; the left-word
    // half mixes the freshly updated right word with keys a and b.
    always_comb begin
        src    = UPDATE_RIGHT ? i_block.left : i_block.right;
        key_lo = UPDATE_RIGHT ? i_key.c : i_key.a;
        key_hi = UPDATE_RIGHT ? i_key.d : i_key.b;
        mix    = ((src << 4) + key_lo) ^ (src + ROUND_SUM) ^ ((src >> 5) + key_hi);
        n_block = i_block;
        if (UPDATE_RIGHT) begin
            n_block.right = i_block.right - mix;
        end else begin
            n_block.left = i_block.left - mix;
        end
    end

    assign o_ready = !r_valid || i_next_ready;
    assign load    = i_valid && o_ready;
    assign n_valid = load || (r_valid && !i_next_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_block <= n_block;
        end
    end

    assign o_valid = r_valid;
    assign o_block = r_block;

    `TBD_ASSERT_NEXT(a_cell_hold, i_clk, i_rst_n, r_valid && !i_next_ready, r_valid && (r_block == $past(r_block)), "stalled cell lost or changed its word")
    `TBD_ASSERT_NEXT(a_cell_load, i_clk, i_rst_n, i_valid && o_ready, r_valid, "accepted word not held by cell")
    `TBD_ASSERT_NEXT(a_cell_drain, i_clk, i_rst_n, r_valid && i_next_ready && !i_valid, !r_valid, "cell kept a word that was passed on")

endmodule

// ----- rtl/core/tea_block_decrypt_core.sv -----
// Top level of the TEA block decryption core: key bank and half-round cell chain.
// Depends on tbd_pkg, tbd_channels_if, tbd_key_bank, tbd_half_cell and the macro header.
//
// Usage:
// A ciphertext word (cipher_left, cipher_right) enters on the i_cipher channel and
// the decrypted word (plain_left, plain_right) leaves on the o_plain channel; both
// use valid/ready and a word moves on a clock edge where both are high.
// The 128-bit key sits in four 32-bit registers written through the plain config
// port (i_cfg_we, i_cfg_index, i_cfg_data); write them only while no word is in
// flight. Reset loads the key words 128, 129, 130 and 131 and empties the chain.
// The design is a row of 2 * ROUND_COUNT cells. Each cell performs half a TEA round
// (first the right word, then the left word) with its round sum fixed at build time,
// and registers the result, so a word passes through every cell register in turn
// before it leaves; one word is accepted every cycle until a receiver stall has
// filled every cell.
// The last cell is the output register. When the receiver stalls, words keep moving
// into empty cells behind the stalled one, so gaps close up; input ready drops only
// once every cell holds a word, and nothing is lost or reordered.
// A cell's depth is one 32-bit add, an XOR and a subtract, which sets the clock.
`include "tea_block_decrypt_core_macros.svh"

module tea_block_decrypt_core #(
    parameter int unsigned ROUND_COUNT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tbd_pkg::KEY_IDX_W-1:0] i_cfg_index,
    input  logic [tbd_pkg::WORD_W-1:0]    i_cfg_data,
    tbd_cipher_if.sink                    i_cipher,
    tbd_plain_if.source                   o_plain
);
    import tbd_pkg::*;

    localparam int unsigned CELL_COUNT = 2 * ROUND_COUNT;

    t_key   key;
    logic   chain_valid [CELL_COUNT+1];
    logic   chain_ready [CELL_COUNT+1];
    t_block chain_block [CELL_COUNT+1];

    tbd_key_bank u_key_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (key)
    );

    // The chain head is the input channel and its tail the output channel.
    assign chain_valid[0]       = i_cipher.valid;
    assign chain_block[0].left  = i_cipher.cipher_left;
    assign chain_block[0].right = i_cipher.cipher_right;
    assign i_cipher.ready       = chain_ready[0];

    assign o_plain.valid           = chain_valid[CELL_COUNT];
    assign o_plain.plain_left      = chain_block[CELL_COUNT].left;
    assign o_plain.plain_right     = chain_block[CELL_COUNT].right;
    assign chain_ready[CELL_COUNT] = o_plain.ready;

    // Cell g belongs to round g / 2; the running sum of round r is
    // (ROUND_COUNT - r) * delta, counting down by delta per round.
    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        localparam int unsigned ROUND_IDX = g / 2;
        localparam bit          IS_RIGHT  = ((g % 2) == 0);
        localparam t_word       SUM       = round_sum(ROUND_COUNT - ROUND_IDX);

        tbd_half_cell #(
            .UPDATE_RIGHT (IS_RIGHT),
            .ROUND_SUM    (SUM)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (chain_valid[g]),
            .o_ready      (chain_ready[g]),
            .i_block      (chain_block[g]),
            .i_key        (key),
            .o_valid      (chain_valid[g+1]),
            .i_next_ready (chain_ready[g+1]),
            .o_block      (chain_block[g+1])
        );
    end

    // Input back-pressure only appears once the output itself is stalled.
    `TBD_ASSERT_IMPLY(a_full_means_stalled, i_clk, i_rst_n, !i_cipher.ready, o_plain.valid && !o_plain.ready, "input stalled while output free")
    // A free output register always lets the chain accept.
    `TBD_ASSERT_IMPLY(a_free_tail_accepts, i_clk, i_rst_n, !o_plain.valid, i_cipher.ready, "input stalled with empty output")
    // A word leaving while nothing new arrives leaves room at the output.
    `TBD_ASSERT_NEXT(a_tail_room, i_clk, i_rst_n, o_plain.valid && o_plain.ready && !i_cipher.valid, i_cipher.ready, "no room after output taken")

endmodule

// ----- tb/tea_block_decrypt_core_tb.sv -----
// Self-checking testbench for the TEA block decryption core.
// Depends on tbd_pkg, the channel interfaces and tea_block_decrypt_core.
module tea_block_decrypt_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbd_pkg::*;

    localparam int unsigned ROUNDS         = 32;
    localparam int unsigned PIPE_DEPTH     = 2 * ROUNDS;
    localparam int unsigned STALL_LIMIT    = 1000;
    localparam int unsigned PHASES         = 9;
    localparam int unsigned WORDS_PER_PHASE = 200;
    localparam int unsigned IDLE_STRETCH   = 50;
    localparam int unsigned MAX_GAP        = 11;

    // The scoreboard keeps its own copy of the key and turns every accepted
    // ciphertext word into the plaintext word that must come out, in order.
    class plain_tracker;
        t_key   key;
        t_block plain_expected[$];
        int     errors;
        int     blocks;

        function new();
            key    = '{a: KEY_A_RESET, b: KEY_B_RESET, c: KEY_C_RESET, d: KEY_D_RESET};
            errors = 0;
            blocks = 0;
        endfunction

        function void set_key_word(logic [KEY_IDX_W-1:0] idx, t_word value);
            case (idx)
                KEY_IDX_A: key.a = value;
                KEY_IDX_B: key.b = value;
                KEY_IDX_C: key.c = value;
                KEY_IDX_D: key.d = value;
                default: ;
            endcase
        endfunction

        // Standard TEA decryption: the sum starts at rounds * delta and walks back.
        function t_block tea_decrypt(t_block cipher);
            t_word  left;
            t_word  right;
            t_word  sum;
            t_block plain;
            left  = cipher.left;
            right = cipher.right;
            sum   = '0;
            repeat (ROUNDS) sum = sum + TEA_DELTA;
            repeat (ROUNDS) begin
                right = right - (((left << 4) + key.c) ^ (left + sum) ^ ((left >> 5) + key.d));
                left  = left - (((right << 4) + key.a) ^ (right + sum) ^ ((right >> 5) + key.b));
                sum   = sum - TEA_DELTA;
            end
            plain.left  = left;
            plain.right = right;
            return plain;
        endfunction

        function void note_cipher(t_block cipher);
            plain_expected.push_back(tea_decrypt(cipher));
        endfunction

        function void check_plain(t_block plain);
            t_block want;
            if (plain_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected plaintext word left=%h right=%h",
                         $time, plain.left, plain.right);
                return;
            end
            want = plain_expected.pop_front();
            blocks++;
            if (plain.left !== want.left) begin
                errors++;
                $display("%0t: plain_left mismatch: expected %h, got %h",
                         $time, want.left, plain.left);
            end
            if (plain.right !== want.right) begin
                errors++;
                $display("%0t: plain_right mismatch: expected %h, got %h",
                         $time, want.right, plain.right);
            end
        endfunction

        function int pending();
            return plain_expected.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [KEY_IDX_W-1:0] i_cfg_index;
    t_word                i_cfg_data;

    tbd_cipher_if cipher_ch ();
    tbd_plain_if  plain_ch ();

    tea_block_decrypt_core #(
        .ROUND_COUNT(ROUNDS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_cipher   (cipher_ch),
        .o_plain    (plain_ch)
    );

    plain_tracker tracker = new();

    // When an idle flag is clear, that side runs without gaps; the flags are
    // redrawn every few dozen words so both busy and sparse stretches occur.
    bit sender_idles;
    bit receiver_idles;
    int key_settings;
    int stall_cycles;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int draw_gap(bit idles);
        return idles ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // Mostly full-range words, with all-zero, all-one and one-hot values mixed in.
    function automatic t_word random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return t_word'(1) << $urandom_range(0, WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // Offers one ciphertext word and returns at the edge that accepts it.
    // The valid line is only lowered when a gap follows, so back-to-back words
    // never see two assignments to valid in the same time step.
    task automatic send_cipher(input t_word left, input t_word right);
        int     gap;
        t_block cipher;
        gap = draw_gap(sender_idles);
        if (gap > 0) begin
            cipher_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cipher_ch.valid        <= 1'b1;
        cipher_ch.cipher_left  <= left;
        cipher_ch.cipher_right <= right;
        @(posedge i_clk);
        while (!cipher_ch.ready) @(posedge i_clk);
        cipher.left  = left;
        cipher.right = right;
        tracker.note_cipher(cipher);
    endtask

    // Waits until every expected plaintext word has come out, with the
    // sender already quiet, so the key may be changed safely.
    task automatic drain();
        cipher_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Writes all four key words on consecutive edges; the tracker follows
    // each write at the edge where it lands.
    task automatic load_key(input t_key k);
        t_word words[4];
        words = '{k.a, k.b, k.c, k.d};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= KEY_IDX_W'(i);
            i_cfg_data  <= words[i];
            @(posedge i_clk);
            tracker.set_key_word(KEY_IDX_W'(i), words[i]);
        end
        i_cfg_we <= 1'b0;
        key_settings++;
    endtask

    // The first settings hit the corners of the key space; later ones are random.
    function automatic t_key key_for_phase(int phase);
        t_key k;
        case (phase)
            1:       k = '{a: '0, b: '0, c: '0, d: '0};
            2:       k = '{a: '1, b: '1, c: '1, d: '1};
            3:       k = '{a: 32'haaaa_aaaa, b: 32'h5555_5555, c: 32'haaaa_aaaa,
                           d: 32'h5555_5555};
            4:       k = '{a: '1, b: '0, c: '1, d: '0};
            default: k = '{a: $urandom, b: $urandom, c: $urandom, d: $urandom};
        endcase
        return k;
    endfunction

    // Receiver: draws a stall before every word, then holds ready high until
    // one word is taken. Sampling right after the edge sees the values that
    // the edge itself used.
    initial begin : receiver
        int     gap;
        t_block plain;
        plain_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(receiver_idles);
            if (gap > 0) begin
                plain_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            plain_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!plain_ch.valid) @(posedge i_clk);
            plain.left  = plain_ch.plain_left;
            plain.right = plain_ch.plain_right;
            tracker.check_plain(plain);
        end
    end

    // Watchdog: a run that moves no word on either channel for too long is hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cipher_ch.valid && cipher_ch.ready)
                || (plain_ch.valid && plain_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        t_word directed_words[12][2];
        directed_words = '{
            '{32'h0000_0000, 32'h0000_0000}, '{32'hffff_ffff, 32'hffff_ffff},
            '{32'h0000_0000, 32'hffff_ffff}, '{32'hffff_ffff, 32'h0000_0000},
            '{32'h8000_0000, 32'h0000_0001}, '{32'h0000_0001, 32'h8000_0000},
            '{32'haaaa_aaaa, 32'h5555_5555}, '{32'h5555_5555, 32'haaaa_aaaa},
            '{32'h0000_001f, 32'hf800_0000}, '{32'h7fff_ffff, 32'h8000_0000},
            '{32'h0123_4567, 32'h89ab_cdef}, '{32'hfedc_ba98, 32'h7654_3210}
        };

        // Every input starts at a known value while reset is held.
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = KEY_IDX_A;
        i_cfg_data             = '0;
        cipher_ch.valid        = 1'b0;
        cipher_ch.cipher_left  = '0;
        cipher_ch.cipher_right = '0;
        sender_idles           = 1'b0;
        receiver_idles         = 1'b0;
        key_settings           = 1;
        stall_cycles           = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner words under the reset key, first back to back and then with
        // idling on both sides.
        foreach (directed_words[i]) begin
            if (i == 6) begin
                sender_idles   = 1'b1;
                receiver_idles = 1'b1;
            end
            send_cipher(directed_words[i][0], directed_words[i][1]);
        end

        // Random words under a series of keys; phase zero keeps the reset key.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain();
                load_key(key_for_phase(phase));
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % IDLE_STRETCH == 0) begin
                    sender_idles   = ($urandom_range(0, 2) != 0);
                    receiver_idles = ($urandom_range(0, 2) != 0);
                end
                send_cipher(random_word(), random_word());
            end
        end

        // Let the pipeline empty, then watch a while longer for stray words.
        cipher_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 16) @(posedge i_clk);

        $display("Checked %0d decrypted blocks under %0d key settings,", tracker.blocks,
                 key_settings);
        $display("with random gaps on the sender and stalls on the receiver.");
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
